FILE: src/acts_pkg.sv
// Package: shared types, codes and wrap helpers for the alarm clock time-set controller.
package acts_pkg;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_MODE   = 2'd1;
	localparam logic [1:0] CMD_ADJUST = 2'd2;

	localparam logic [2:0] MODE_NORMAL    = 3'd0;
	localparam logic [2:0] MODE_SET_HOUR  = 3'd1;
	localparam logic [2:0] MODE_SET_MIN   = 3'd2;
	localparam logic [2:0] MODE_SET_SEC   = 3'd3;
	localparam logic [2:0] MODE_ALARM     = 3'd4;
	localparam logic [2:0] MODE_ALARM_HR  = 3'd5;
	localparam logic [2:0] MODE_ALARM_MIN = 3'd6;
	localparam logic [2:0] MODE_ALARM_SEC = 3'd7;

	localparam logic [15:0] TPS_RESET = 16'd100;
	localparam logic [4:0]  HOUR_LAST = 5'd23;
	localparam logic [5:0]  SIXTY_LAST = 6'd59;

	typedef struct packed {
		logic [1:0] command;
		logic       alarm_sounding;
	} acts_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] clock_hour;
		logic [5:0] clock_minute;
		logic [5:0] clock_second;
		logic [4:0] alarm_hour;
		logic [5:0] alarm_minute;
		logic [5:0] alarm_second;
		logic       alarm_armed;
		logic       alarm_off_request;
		logic       alarm_led_clear;
	} acts_res_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] tick_count;
		logic [4:0]  time_hour;
		logic [5:0]  time_minute;
		logic [5:0]  time_second;
		logic [4:0]  wake_hour;
		logic [5:0]  wake_minute;
		logic [5:0]  wake_second;
		logic        armed;
	} acts_state_t;

	function automatic logic [4:0] inc_hour(input logic [4:0] v);
		return (v >= HOUR_LAST) ? 5'd0 : v + 5'd1;
	endfunction

	function automatic logic [5:0] inc_sixty(input logic [5:0] v);
		return (v >= SIXTY_LAST) ? 6'd0 : v + 6'd1;
	endfunction

endpackage

FILE: src/acts_next.sv
// Next-state logic: applies one command word to the clock, alarm and mode state.
module acts_next
	import acts_pkg::*;
(
	input  acts_state_t cur,
	input  acts_cmd_t   cmd,
	input  logic [15:0] ticks_per_second,
	output acts_state_t nxt,
	output logic        off_req,
	output logic        led_clear
);

	logic [16:0] tick_inc;
	logic        sec_done;

	assign tick_inc = {1'b0, cur.tick_count} + 17'd1;
	// a zero register behaves as one tick per second
	assign sec_done = (tick_inc >= {1'b0, ticks_per_second});

	always_comb begin
		nxt       = cur;
		off_req   = 1'b0;
		led_clear = 1'b0;
		case (cmd.command)
			CMD_TICK: begin
				if (!(cur.mode inside {[MODE_SET_HOUR:MODE_SET_SEC]})) begin
					if (sec_done) begin
						nxt.tick_count  = '0;
						nxt.time_second = inc_sixty(cur.time_second);
						if (cur.time_second >= SIXTY_LAST) begin
							nxt.time_minute = inc_sixty(cur.time_minute);
							if (cur.time_minute >= SIXTY_LAST)
								nxt.time_hour = inc_hour(cur.time_hour);
						end
					end else begin
						nxt.tick_count = tick_inc[15:0];
					end
				end
			end
			CMD_MODE: begin
				if (cmd.alarm_sounding) begin
					off_req = 1'b1;
				end else begin
					case (cur.mode)
						MODE_SET_SEC: nxt.mode = MODE_NORMAL;
						MODE_ALARM_SEC: begin
							nxt.mode  = MODE_NORMAL;
							nxt.armed = 1'b1;
						end
						default: nxt.mode = cur.mode + 3'd1;
					endcase
				end
			end
			CMD_ADJUST: begin
				if (cmd.alarm_sounding) begin
					off_req = 1'b1;
				end else begin
					case (cur.mode)
						MODE_NORMAL: begin
							nxt.mode  = MODE_ALARM;
							nxt.armed = 1'b0;
							led_clear = 1'b1;
						end
						MODE_SET_HOUR:  nxt.time_hour   = inc_hour(cur.time_hour);
						MODE_SET_MIN:   nxt.time_minute = inc_sixty(cur.time_minute);
						MODE_SET_SEC:   nxt.time_second = inc_sixty(cur.time_second);
						MODE_ALARM:     nxt.mode        = MODE_NORMAL;
						MODE_ALARM_HR:  nxt.wake_hour   = inc_hour(cur.wake_hour);
						MODE_ALARM_MIN: nxt.wake_minute = inc_sixty(cur.wake_minute);
						default:        nxt.wake_second = inc_sixty(cur.wake_second);
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: src/alarm_clock_time_set_controller_unit.sv
// Top level of the alarm clock time-set controller.
// Usage:
//  - Command channel (cmd_valid/cmd_stall/cmd): one word per event, a timer tick,
//    a mode-button press or an adjust-button press, plus the alarm-sounding flag.
//  - Result channel (res_valid/res_stall/res): exactly one word per command word,
//    showing mode, clock and alarm time and the armed flag after the event, with
//    the alarm-off-request and lamp-clear pulses for that event.
//  - cfg_we/cfg_wdata write ticks_per_second; write only while the block is idle.
// A command word accepted into the input register is applied to the state as it
// moves into the result register, where its result word becomes valid. One word
// per cycle is sustained while res_stall is low; the next-state logic between the
// input register and the result register is a single pass of small increments.
// Reset clears mode, prescaler, clock and alarm times and the armed flag, and
// sets ticks_per_second to 100; no word is pending afterwards.
// When res_stall holds a word in the result register, the input register keeps
// one more word and cmd_stall rises only once both are full.
module alarm_clock_time_set_controller_unit
	import acts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  acts_cmd_t   cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output acts_res_t   res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic        valid_s1;
	acts_cmd_t   cmd_s1;
	logic        res_valid_q;
	acts_res_t   res_q;
	acts_state_t st_q;
	acts_state_t st_nxt;
	logic [15:0] tps_q;
	logic        off_req;
	logic        led_clear;
	logic        advance;

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && res_valid_q && res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	acts_next u_next (
		.cur              (st_q),
		.cmd              (cmd_s1),
		.ticks_per_second (tps_q),
		.nxt              (st_nxt),
		.off_req          (off_req),
		.led_clear        (led_clear)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_we) begin
			tps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid)
			cmd_s1 <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			st_q        <= st_nxt;
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.mode              <= st_nxt.mode;
			res_q.clock_hour        <= st_nxt.time_hour;
			res_q.clock_minute      <= st_nxt.time_minute;
			res_q.clock_second      <= st_nxt.time_second;
			res_q.alarm_hour        <= st_nxt.wake_hour;
			res_q.alarm_minute      <= st_nxt.wake_minute;
			res_q.alarm_second      <= st_nxt.wake_second;
			res_q.alarm_armed       <= st_nxt.armed;
			res_q.alarm_off_request <= off_req;
			res_q.alarm_led_clear   <= led_clear;
		end
	end

endmodule

FILE: src/acts_checker.sv
// Checker: port-level assertions for the alarm clock time-set controller, and its bind.
module acts_checker
	import acts_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input acts_cmd_t cmd,
	input logic      res_valid,
	input logic      res_stall,
	input acts_res_t res
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result word changed under stall");

	// entering the alarm menu disarms
	a_led_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.alarm_led_clear |-> res.mode == MODE_ALARM && !res.alarm_armed)
		else $error("lamp clear without alarm menu entry");

	a_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.alarm_off_request && res.alarm_led_clear))
		else $error("both pulses in one word");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.clock_hour <= HOUR_LAST && res.clock_minute <= SIXTY_LAST
			&& res.clock_second <= SIXTY_LAST && res.alarm_hour <= HOUR_LAST
			&& res.alarm_minute <= SIXTY_LAST && res.alarm_second <= SIXTY_LAST)
		else $error("time field out of range");

	// input stalls only while a result word is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("command stalled without result back-pressure");

endmodule

bind alarm_clock_time_set_controller_unit acts_checker u_acts_checker (.*);
